[hdl/iee_pkg.sv]
`timescale 1ns / 1ps

package iee_pkg;

   // Pending operator codes
   typedef enum logic [1:0] {
      OP_ADD = 2'd0,
      OP_SUB = 2'd1,
      OP_MUL = 2'd2,
      OP_DIV = 2'd3
   } op_type;

   // ASCII codes of interest
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_NINE  = 8'h39;
   localparam logic [7:0] CHAR_PLUS  = 8'h2B;
   localparam logic [7:0] CHAR_MINUS = 8'h2D;
   localparam logic [7:0] CHAR_STAR  = 8'h2A;
   localparam logic [7:0] CHAR_SLASH = 8'h2F;

   // Control into the multiply/divide unit
   typedef struct packed {
      logic start;
      logic div;
   } md_ctrl_type;

   // Status out of the multiply/divide unit
   typedef struct packed {
      logic busy;
      logic done;
   } md_stat_type;

endpackage

[hdl/iee_if.sv]
`timescale 1ns / 1ps

// Request channel: one character per request
interface iee_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] ch;
   logic       last;

   modport source (output valid, output ch, output last, input ready);
   modport sink   (input valid, input ch, input last, output ready);
endinterface

// Response channel: one result per expression
interface iee_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] value;
   logic               div_zero;

   modport source (output valid, output value, output div_zero, input ready);
   modport sink   (input valid, input value, input div_zero, output ready);
endinterface

[hdl/iee_muldiv.sv]
`timescale 1ns / 1ps

// Shared one-bit-per-cycle unit: shift-add multiply, restoring signed divide.
// Steps through the operand bits, then raises done for a single cycle with the result valid.
module iee_muldiv #(
   parameter int WORD_WIDTH = 32
) (
   input  logic                    clock,
   input  logic                    reset,
   input  iee_pkg::md_ctrl_type    ctrl,
   input  logic [WORD_WIDTH-1:0]   opnd_a,
   input  logic [WORD_WIDTH-1:0]   opnd_b,
   output iee_pkg::md_stat_type    stat,
   output logic [WORD_WIDTH-1:0]   result
);

   localparam int CW = $clog2(WORD_WIDTH);

   logic                  busy_ff, busy_in;
   logic                  fin_ff, fin_in;
   logic [CW-1:0]         cnt_ff, cnt_in;
   logic                  div_ff, div_in;
   logic                  neg_ff, neg_in;
   logic [WORD_WIDTH-1:0] acc_ff, acc_in;   // product / remainder
   logic [WORD_WIDTH-1:0] opa_ff, opa_in;   // multiplicand / divisor
   logic [WORD_WIDTH-1:0] opb_ff, opb_in;   // multiplier / dividend-quotient

   logic                  a_neg, b_neg;
   logic [WORD_WIDTH-1:0] mag_a, mag_b;
   logic [WORD_WIDTH:0]   add_x, add_y, add_sum;
   logic                  ge;

   // Operand magnitudes for the divide
   assign a_neg = opnd_a[WORD_WIDTH-1];
   assign b_neg = opnd_b[WORD_WIDTH-1];
   assign mag_a = a_neg ? ('0 - opnd_a) : opnd_a;
   assign mag_b = b_neg ? ('0 - opnd_b) : opnd_b;

   // The one shared adder: add for multiply, trial subtract for divide
   assign add_x   = div_ff ? {acc_ff, opb_ff[WORD_WIDTH-1]} : {1'b0, acc_ff};
   assign add_y   = {1'b0, opa_ff};
   assign add_sum = add_x + (div_ff ? ~add_y : add_y) + (WORD_WIDTH+1)'(div_ff);
   assign ge      = ~add_sum[WORD_WIDTH];

   // Step sequencing
   always_comb begin
      busy_in = busy_ff;
      fin_in  = 1'b0;
      cnt_in  = cnt_ff;
      div_in  = div_ff;
      neg_in  = neg_ff;
      acc_in  = acc_ff;
      opa_in  = opa_ff;
      opb_in  = opb_ff;
      if (ctrl.start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         div_in  = ctrl.div;
         neg_in  = ctrl.div & (a_neg ^ b_neg);
         acc_in  = '0;
         opa_in  = ctrl.div ? mag_b : opnd_a;
         opb_in  = ctrl.div ? mag_a : opnd_b;
      end else if (busy_ff) begin
         if (div_ff) begin
            acc_in = ge ? add_sum[WORD_WIDTH-1:0] : add_x[WORD_WIDTH-1:0];
            opb_in = {opb_ff[WORD_WIDTH-2:0], ge};
         end else begin
            if (opb_ff[0]) begin
               acc_in = add_sum[WORD_WIDTH-1:0];
            end
            opa_in = opa_ff << 1;
            opb_in = opb_ff >> 1;
         end
         cnt_in = cnt_ff + CW'(1);
         if (cnt_ff == CW'(WORD_WIDTH-1)) begin
            busy_in = 1'b0;
            fin_in  = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         fin_ff  <= 1'b0;
         cnt_ff  <= '0;
         div_ff  <= 1'b0;
         neg_ff  <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         fin_ff  <= fin_in;
         cnt_ff  <= cnt_in;
         div_ff  <= div_in;
         neg_ff  <= neg_in;
      end
      acc_ff <= acc_in;
      opa_ff <= opa_in;
      opb_ff <= opb_in;
   end

   // Result, with quotient sign fix-up
   assign result    = div_ff ? (neg_ff ? ('0 - opb_ff) : opb_ff) : acc_ff;
   assign stat.busy = busy_ff;
   assign stat.done = fin_ff;

   // Checks
   a_div_nonzero: assert property (@(posedge clock) disable iff (reset)
      busy_ff && div_ff |-> opa_ff != '0)
      else $error("divide running with zero divisor");

   a_fin_after_busy: assert property (@(posedge clock) disable iff (reset)
      fin_ff |-> $past(busy_ff))
      else $error("done without a preceding step cycle");

   a_phase_excl: assert property (@(posedge clock) disable iff (reset)
      !(busy_ff && fin_ff))
      else $error("unit busy and done at once");

endmodule

[hdl/infix_expression_evaluator.sv]
`timescale 1ns / 1ps

// Infix expression evaluator (+ - * / with usual precedence).
// req_if carries one ASCII character per request, with last set on the final
// character of an expression. Digits build a number, operators apply the
// pending operator, everything else is skipped. After the final character one
// response goes out on rsp_if: the signed 32-bit result and a flag telling
// whether any division by zero occurred (that term is then left unchanged).
// Sequencing: a digit or skipped character is taken in ST_IDLE. An operator
// or final character applies the pending operator in ST_APPLY: + and -, and a
// division by zero, are done there; * and / go on in ST_MULDIV, waiting for the
// shared multiply/divide unit, which handles one bit per cycle. A final
// character then passes through ST_FINISH to load the response register.
// req_if.ready is high only while the sequencer is idle.
// The response sits in an output register; while it is not taken, further
// characters of the next expression are still accepted, and only the next
// final character waits for the register to free up.
// Reset (synchronous) clears the expression state and drops any response.
module infix_expression_evaluator #(
   parameter int WORD_WIDTH = 32
) (
   input logic      clock,
   input logic      reset,
   iee_req_if.sink  req_if,
   iee_rsp_if.source rsp_if
);

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_APPLY  = 4'b0010,
      ST_MULDIV = 4'b0100,
      ST_FINISH = 4'b1000
   } state_type;

   state_type             state_ff, state_in;
   logic [WORD_WIDTH-1:0] number_ff, number_in;
   logic [WORD_WIDTH-1:0] sum_ff, sum_in;
   logic [WORD_WIDTH-1:0] term_ff, term_in;
   iee_pkg::op_type       pend_ff, pend_in;
   iee_pkg::op_type       nextop_ff, nextop_in;
   logic                  nextop_vld_ff, nextop_vld_in;
   logic                  fin_ff, fin_in;
   logic                  error_ff, error_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [31:0]           rsp_value_ff, rsp_value_in;
   logic                  rsp_dz_ff, rsp_dz_in;

   logic                  accept;
   logic                  is_digit, is_op;
   logic [3:0]            digit_raw;
   iee_pkg::op_type       op_dec;
   logic [WORD_WIDTH+31:0] total_ext;

   iee_pkg::md_ctrl_type  md_ctrl;
   iee_pkg::md_stat_type  md_stat;
   logic [WORD_WIDTH-1:0] md_result;

   // Character decode
   assign accept    = req_if.valid && req_if.ready;
   assign is_digit  = (req_if.ch >= iee_pkg::CHAR_ZERO) && (req_if.ch <= iee_pkg::CHAR_NINE);
   assign is_op     = (req_if.ch == iee_pkg::CHAR_PLUS) || (req_if.ch == iee_pkg::CHAR_MINUS)
                   || (req_if.ch == iee_pkg::CHAR_STAR) || (req_if.ch == iee_pkg::CHAR_SLASH);
   // low nibble of '0'..'9' is the digit value
   assign digit_raw = req_if.ch[3:0];

   always_comb begin
      case (req_if.ch)
         iee_pkg::CHAR_MINUS: op_dec = iee_pkg::OP_SUB;
         iee_pkg::CHAR_STAR:  op_dec = iee_pkg::OP_MUL;
         iee_pkg::CHAR_SLASH: op_dec = iee_pkg::OP_DIV;
         default:             op_dec = iee_pkg::OP_ADD;
      endcase
   end

   // Final value, truncated or zero-extended to 32 bits
   assign total_ext = {32'b0, sum_ff + term_ff};

   // Sequencer
   always_comb begin
      state_in      = state_ff;
      number_in     = number_ff;
      sum_in        = sum_ff;
      term_in       = term_ff;
      pend_in       = pend_ff;
      nextop_in     = nextop_ff;
      nextop_vld_in = nextop_vld_ff;
      fin_in        = fin_ff;
      error_in      = error_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_value_in  = rsp_value_ff;
      rsp_dz_in     = rsp_dz_ff;
      md_ctrl.start = 1'b0;
      md_ctrl.div   = 1'b0;

      if (rsp_valid_ff && rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (is_digit) begin
                  // number * 10 + digit
                  number_in = (number_ff << 3) + (number_ff << 1)
                            + WORD_WIDTH'(digit_raw);
               end
               if (is_op || req_if.last) begin
                  nextop_in     = op_dec;
                  nextop_vld_in = is_op;
                  fin_in        = req_if.last;
                  state_in      = ST_APPLY;
               end
            end
         end
         ST_APPLY: begin
            state_in = fin_ff ? ST_FINISH : ST_IDLE;
            case (pend_ff)
               iee_pkg::OP_ADD: begin
                  sum_in  = sum_ff + term_ff;
                  term_in = number_ff;
               end
               iee_pkg::OP_SUB: begin
                  sum_in  = sum_ff + term_ff;
                  term_in = '0 - number_ff;
               end
               iee_pkg::OP_MUL: begin
                  md_ctrl.start = 1'b1;
                  state_in      = ST_MULDIV;
               end
               default: begin
                  if (number_ff == '0) begin
                     error_in = 1'b1;
                  end else begin
                     md_ctrl.start = 1'b1;
                     md_ctrl.div   = 1'b1;
                     state_in      = ST_MULDIV;
                  end
               end
            endcase
            number_in = '0;
            if (nextop_vld_ff) begin
               pend_in = nextop_ff;
            end
         end
         ST_MULDIV: begin
            if (md_stat.done) begin
               term_in  = md_result;
               state_in = fin_ff ? ST_FINISH : ST_IDLE;
            end
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_if.ready) begin
               rsp_valid_in = 1'b1;
               rsp_value_in = total_ext[31:0];
               rsp_dz_in    = error_ff;
               number_in    = '0;
               sum_in       = '0;
               term_in      = '0;
               pend_in      = iee_pkg::OP_ADD;
               error_in     = 1'b0;
               fin_in       = 1'b0;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         number_ff     <= '0;
         sum_ff        <= '0;
         term_ff       <= '0;
         pend_ff       <= iee_pkg::OP_ADD;
         nextop_vld_ff <= 1'b0;
         fin_ff        <= 1'b0;
         error_ff      <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         number_ff     <= number_in;
         sum_ff        <= sum_in;
         term_ff       <= term_in;
         pend_ff       <= pend_in;
         nextop_vld_ff <= nextop_vld_in;
         fin_ff        <= fin_in;
         error_ff      <= error_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      nextop_ff    <= nextop_in;
      rsp_value_ff <= rsp_value_in;
      rsp_dz_ff    <= rsp_dz_in;
   end

   // Shared multiply/divide unit: open term op current number
   iee_muldiv #(
      .WORD_WIDTH (WORD_WIDTH)
   ) u_muldiv (
      .clock  (clock),
      .reset  (reset),
      .ctrl   (md_ctrl),
      .opnd_a (term_ff),
      .opnd_b (number_ff),
      .stat   (md_stat),
      .result (md_result)
   );

   // Ports
   assign req_if.ready    = (state_ff == ST_IDLE);
   assign rsp_if.valid    = rsp_valid_ff;
   assign rsp_if.value    = rsp_value_ff;
   assign rsp_if.div_zero = rsp_dz_ff;

   // Checks
   a_rsp_from_finish: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_FINISH))
      else $error("response raised outside finish");

   a_start_unit_free: assert property (@(posedge clock) disable iff (reset)
      md_ctrl.start |-> !md_stat.busy && !md_stat.done)
      else $error("unit started while in use");

   a_done_in_wait: assert property (@(posedge clock) disable iff (reset)
      md_stat.done |-> state_ff == ST_MULDIV)
      else $error("unit result arrived outside wait state");

   a_divzero_flag: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_APPLY && pend_ff == iee_pkg::OP_DIV && number_ff == '0
      |=> error_ff)
      else $error("division by zero not flagged");

endmodule

[test/tb_infix_expression_evaluator.sv]
`timescale 1ns / 1ps

// Tracks the expression state and holds the results still owed by the block
class expr_scoreboard;

   typedef struct {
      logic signed [31:0] value;
      logic               div_zero;
   } expr_result_type;

   logic [31:0]      digits_acc;
   logic [31:0]      sum_acc;
   logic [31:0]      term_acc;
   iee_pkg::op_type  pend_op;
   logic             div_err;

   expr_result_type owed_q[$];
   int              errors;
   int              checked;
   int              div_zero_results;

   function new();
      errors           = 0;
      checked          = 0;
      div_zero_results = 0;
      clear_state();
   endfunction

   function void clear_state();
      digits_acc = '0;
      sum_acc    = '0;
      term_acc   = '0;
      pend_op    = iee_pkg::OP_ADD;
      div_err    = 1'b0;
   endfunction

   // Signed quotient truncated towards zero, wrapping at 32 bits
   function logic [31:0] trunc_quotient(logic [31:0] a, logic [31:0] b);
      logic [31:0] mag_a;
      logic [31:0] mag_b;
      logic [31:0] q;
      mag_a = a[31] ? -a : a;
      mag_b = b[31] ? -b : b;
      q     = mag_a / mag_b;
      if (a[31] != b[31]) begin
         q = -q;
      end
      return q;
   endfunction

   // One accepted character request
   function void note_char(logic [7:0] c, logic fin);
      expr_result_type r;
      logic [31:0]     n;
      if (c >= iee_pkg::CHAR_ZERO && c <= iee_pkg::CHAR_NINE) begin
         digits_acc = digits_acc * 32'd10 + 32'(c - iee_pkg::CHAR_ZERO);
      end
      if (c == iee_pkg::CHAR_PLUS || c == iee_pkg::CHAR_MINUS ||
          c == iee_pkg::CHAR_STAR || c == iee_pkg::CHAR_SLASH || fin) begin
         n = digits_acc;
         case (pend_op)
            iee_pkg::OP_ADD: begin
               sum_acc  = sum_acc + term_acc;
               term_acc = n;
            end
            iee_pkg::OP_SUB: begin
               sum_acc  = sum_acc + term_acc;
               term_acc = -n;
            end
            iee_pkg::OP_MUL: begin
               term_acc = term_acc * n;
            end
            default: begin
               // divide by zero leaves the term alone
               if (n == 0) begin
                  div_err = 1'b1;
               end else begin
                  term_acc = trunc_quotient(term_acc, n);
               end
            end
         endcase
         digits_acc = '0;
         case (c)
            iee_pkg::CHAR_PLUS:  pend_op = iee_pkg::OP_ADD;
            iee_pkg::CHAR_MINUS: pend_op = iee_pkg::OP_SUB;
            iee_pkg::CHAR_STAR:  pend_op = iee_pkg::OP_MUL;
            iee_pkg::CHAR_SLASH: pend_op = iee_pkg::OP_DIV;
            default: ;
         endcase
      end
      if (fin) begin
         r.value    = sum_acc + term_acc;
         r.div_zero = div_err;
         owed_q.insert(owed_q.size(), r);
         clear_state();
      end
   endfunction

   // One accepted response
   function void check_result(logic signed [31:0] value, logic div_zero);
      expr_result_type r;
      if (owed_q.size() == 0) begin
         $display("%0t: unexpected response value %0d div_zero %0b", $time, value, div_zero);
         errors++;
         return;
      end
      r = owed_q[0];
      owed_q.delete(0);
      checked++;
      if (div_zero) begin
         div_zero_results++;
      end
      if (value !== r.value) begin
         $display("%0t: value mismatch, expected %0d, actual %0d", $time, r.value, value);
         errors++;
      end
      if (div_zero !== r.div_zero) begin
         $display("%0t: div_zero mismatch, expected %0b, actual %0b",
                  $time, r.div_zero, div_zero);
         errors++;
      end
   endfunction

   function int outstanding();
      return owed_q.size();
   endfunction

endclass

module tb_infix_expression_evaluator;

   localparam int CHAR_TARGET = 1450;

   logic clock;
   logic reset;

   iee_req_if req();
   iee_rsp_if rsp();

   expr_scoreboard sb;

   int  expr_count;
   int  chars_sent;
   int  useful_count;
   bit  rsp_burst;

   infix_expression_evaluator #(
      .WORD_WIDTH(32)
   ) dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req),
      .rsp_if (rsp)
   );

   // Clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Hard stop in case the block hangs
   initial begin
      #8ms;
      $display("%0t: timeout with %0d results outstanding", $time, sb.outstanding());
      $display("TEST FAILED");
      $finish;
   end

   task automatic append_text(ref logic [7:0] q[$], input string s);
      for (int i = 0; i < s.len(); i++) begin
         q.insert(q.size(), s[i]);
      end
   endtask

   // Send one character request, idling first unless in burst
   task automatic send_char(input logic [7:0] c, input logic fin, input bit burst);
      int gap;
      gap = burst ? 0 : $urandom_range(0, 19);
      if (gap > 0) begin
         req.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req.valid <= 1'b1;
      req.ch    <= c;
      req.last  <= fin;
      do @(posedge clock); while (!req.ready);
      sb.note_char(c, fin);
      chars_sent++;
      if ((c >= iee_pkg::CHAR_ZERO && c <= iee_pkg::CHAR_NINE) ||
          c == iee_pkg::CHAR_PLUS || c == iee_pkg::CHAR_MINUS ||
          c == iee_pkg::CHAR_STAR || c == iee_pkg::CHAR_SLASH || fin) begin
         useful_count++;
      end
   endtask

   // Whole expression, last flag on the final character
   task automatic send_expression(ref logic [7:0] q[$], input bit burst);
      for (int i = 0; i < q.size(); i++) begin
         send_char(q[i], i == q.size() - 1, burst);
      end
      expr_count++;
   endtask

   // Mostly well-formed expressions with random numbers, some plain noise
   task automatic build_random_expression(ref logic [7:0] q[$]);
      logic [7:0]      ops[4];
      int              terms;
      longint unsigned n;
      ops = '{iee_pkg::CHAR_PLUS, iee_pkg::CHAR_MINUS, iee_pkg::CHAR_STAR,
              iee_pkg::CHAR_SLASH};
      q.delete();
      if ($urandom_range(0, 4) == 0) begin
         repeat ($urandom_range(1, 12)) begin
            case ($urandom_range(0, 2))
               0:       q.insert(q.size(), 8'($urandom_range(0, 255)));
               1:       q.insert(q.size(), iee_pkg::CHAR_ZERO + 8'($urandom_range(0, 9)));
               default: q.insert(q.size(), ops[$urandom_range(0, 3)]);
            endcase
         end
         return;
      end
      terms = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 12) : $urandom_range(1, 6);
      // leading operator acts on the empty term
      if ($urandom_range(0, 9) == 0) begin
         q.insert(q.size(), ops[$urandom_range(0, 3)]);
      end
      for (int t = 0; t < terms; t++) begin
         if (t > 0) begin
            q.insert(q.size(), ops[$urandom_range(0, 3)]);
         end
         if ($urandom_range(0, 5) == 0) begin
            q.insert(q.size(), 8'h20);
         end
         case ($urandom_range(0, 9))
            0:       n = 0;
            1, 2, 3: n = $urandom_range(1, 9);
            4, 5:    n = $urandom_range(10, 999);
            6:       n = $urandom;
            7:       n = {$urandom, $urandom} % 64'd100_000_000_000;
            8: begin
               case ($urandom_range(0, 3))
                  0:       n = 64'd2147483647;
                  1:       n = 64'd2147483648;
                  2:       n = 64'd4294967295;
                  default: n = 64'd4294967296;
               endcase
            end
            default: n = $urandom_range(0, 99);
         endcase
         if ($urandom_range(0, 7) == 0) begin
            q.insert(q.size(), iee_pkg::CHAR_ZERO);
         end
         append_text(q, $sformatf("%0d", n));
         if ($urandom_range(0, 5) == 0) begin
            q.insert(q.size(),
                     ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255)) : 8'h20);
         end
      end
      // final character that is an operator or something ignored
      if ($urandom_range(0, 9) == 0) begin
         q.insert(q.size(), ($urandom_range(0, 1) == 0) ? ops[$urandom_range(0, 3)] :
                            8'($urandom_range(0, 255)));
      end
   endtask

   task automatic wait_drained();
      while (sb.outstanding() != 0) @(posedge clock);
   endtask

   // Response side: random stalls, with stretches of none
   task automatic take_responses();
      int stall;
      forever begin
         stall = rsp_burst ? 0 : $urandom_range(0, 19);
         if (stall > 0) begin
            rsp.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp.ready <= 1'b1;
         do @(posedge clock); while (!rsp.valid);
         sb.check_result(rsp.value, rsp.div_zero);
         if ($urandom_range(0, 7) == 0) begin
            rsp_burst = !rsp_burst;
         end
      end
   endtask

   // Main sequence
   initial begin
      logic [7:0] q[$];
      bit         burst;
      sb           = new();
      expr_count   = 0;
      chars_sent   = 0;
      useful_count = 0;
      rsp_burst    = 1'b0;
      reset        <= 1'b1;
      req.valid    <= 1'b0;
      req.ch       <= 8'h00;
      req.last     <= 1'b0;
      rsp.ready    <= 1'b0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      fork
         take_responses();
      join_none

      // most negative value over all-ones (-1): quotient wraps back
      q.delete();
      append_text(q, "2147483648/4294967295");
      send_expression(q, 1'b0);
      // space, subtract, divide by zero, final operator dropped
      q.delete();
      append_text(q, " 3-8/0+");
      send_expression(q, 1'b1);
      // top byte ignored, then leading multiply on the empty term
      q.delete();
      q.insert(q.size(), 8'hFF);
      append_text(q, "*5");
      send_expression(q, 1'b0);
      // lone NUL as final character
      q.delete();
      q.insert(q.size(), 8'h00);
      send_expression(q, 1'b0);

      // random expressions
      while (chars_sent < CHAR_TARGET) begin
         if (expr_count == 20 || $urandom_range(0, 49) == 0) begin
            req.valid <= 1'b0;
            wait_drained();
         end
         burst = ($urandom_range(0, 4) == 0);
         build_random_expression(q);
         send_expression(q, burst);
      end
      req.valid <= 1'b0;

      wait_drained();
      repeat (60) @(posedge clock);
      $display("Covered %0d expressions, %0d characters (%0d digits, operators or finals)",
               expr_count, chars_sent, useful_count);
      $display("Checked %0d results, %0d of them with a division by zero",
               sb.checked, sb.div_zero_results);
      if (sb.errors == 0 && sb.outstanding() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

[infix_expression_evaluator.f]
hdl/iee_pkg.sv
hdl/iee_if.sv
hdl/iee_muldiv.sv
hdl/infix_expression_evaluator.sv
test/tb_infix_expression_evaluator.sv
